>>> hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, mode and status codes, and the controller/datapath types.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OperandWidth = 32;
   localparam int WideWidth    = 64;

   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_CMP = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_DIV_ZERO = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // Capture operands.
      logic mult;        // Register the cross products.
      logic combine;     // Form numerator and denominator.
      logic gcd_init;    // Start the Euclid loop.
      logic div_start;   // Start one restoring division.
      logic div_step;    // One quotient bit.
      logic gcd_next;    // Move remainder into the Euclid pair.
      logic quot_num;    // Start the numerator reduction.
      logic save_num;    // Store reduced numerator.
      logic save_den;    // Store reduced denominator.
      logic finish;      // Build the result beat.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic special;     // Error, compare or unused mode: no reduction needed.
      logic num_zero;    // Combined numerator is zero.
      logic y_zero;      // Euclid divisor is zero.
      logic div_last;    // Last division step.
   } stat_type;

endpackage

>>> hw/rtl/rau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Cross products, Euclid loop and exact reduction through one shared
// bit-serial divider.
// ----------------------------------------------------------------------------
module rau_datapath #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rau_pkg::cmd_type           cmd,
   output rau_pkg::stat_type          stat,
   input  logic [2:0]                 in_mode,
   input  logic [OPERAND_WIDTH-1:0]   in_a_num,
   input  logic [OPERAND_WIDTH-2:0]   in_a_den,
   input  logic [OPERAND_WIDTH-1:0]   in_b_num,
   input  logic [OPERAND_WIDTH-2:0]   in_b_den,
   output logic [63:0]                out_num,
   output logic [62:0]                out_den,
   output logic                       out_less,
   output logic                       out_equal,
   output logic [1:0]                 out_status
);

   localparam int W    = rau_pkg::WideWidth;
   localparam int CntW = $clog2(W);

   logic [2:0]                         mode_ff;
   logic signed [OPERAND_WIDTH-1:0]    an_ff, bn_ff;
   logic [OPERAND_WIDTH-2:0]           ad_ff, bd_ff;
   logic signed [W-1:0]                p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [2*OPERAND_WIDTH-1:0]  p0_in, p1_in, p2_in, p3_in;
   logic                    neg_ff;
   logic [W-1:0]            mag_ff, den_ff;
   logic [W-1:0]            x_ff, y_ff;
   logic [W-1:0]            dvd_ff, dvs_ff, rem_ff, quo_ff;
   logic [CntW-1:0]         cnt_ff;
   logic [W-1:0]            rnum_ff;
   logic [1:0]              status_ff;
   logic                    special_ff;
   logic [W:0]              trial;
   logic [W-1:0]            rem_shift;
   logic signed [W-1:0]     num_c, den_c;
   logic                    zero_den, div_zero;

   assign zero_den = (in_a_den == '0) || (in_b_den == '0);
   assign div_zero = (in_b_num == '0);

   assign p0_in = an_ff * $signed({1'b0, bd_ff});
   assign p1_in = $signed({1'b0, ad_ff}) * bn_ff;
   assign p2_in = an_ff * bn_ff;
   assign p3_in = $signed({1'b0, ad_ff}) * $signed({1'b0, bd_ff});

   always_comb begin
      num_c = '0;
      den_c = 64'sd1;
      unique case (mode_ff)
         rau_pkg::MODE_ADD: begin
            num_c = p0_ff + p1_ff;
            den_c = p3_ff;
         end
         rau_pkg::MODE_SUB: begin
            num_c = p0_ff - p1_ff;
            den_c = p3_ff;
         end
         rau_pkg::MODE_MUL: begin
            num_c = p2_ff;
            den_c = p3_ff;
         end
         rau_pkg::MODE_DIV: begin
            num_c = p0_ff;
            den_c = p1_ff;
         end
         default: begin
            num_c = '0;
            den_c = 64'sd1;
         end
      endcase
      if (den_c < 0) begin
         num_c = -num_c;
         den_c = -den_c;
      end
   end

   assign rem_shift = {rem_ff[W-2:0], dvd_ff[W-1]};
   assign trial     = {1'b0, rem_shift} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start || cmd.quot_num) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= in_mode;
         an_ff   <= in_a_num;
         bn_ff   <= in_b_num;
         ad_ff   <= in_a_den;
         bd_ff   <= in_b_den;
         if ((in_mode <= rau_pkg::MODE_CMP) && zero_den) begin
            status_ff  <= rau_pkg::STATUS_ZERO_DEN;
            special_ff <= 1'b1;
         end else if ((in_mode == rau_pkg::MODE_DIV) && div_zero) begin
            status_ff  <= rau_pkg::STATUS_DIV_ZERO;
            special_ff <= 1'b1;
         end else begin
            status_ff  <= rau_pkg::STATUS_OK;
            special_ff <= (in_mode >= rau_pkg::MODE_CMP);
         end
      end
      if (cmd.mult) begin
         p0_ff <= W'(p0_in);
         p1_ff <= W'(p1_in);
         p2_ff <= W'(p2_in);
         p3_ff <= W'(p3_in);
      end
      if (cmd.combine) begin
         neg_ff <= num_c < 0;
         mag_ff <= (num_c < 0) ? W'(-num_c) : W'(num_c);
         den_ff <= W'(den_c);
      end
      if (cmd.gcd_init) begin
         x_ff <= mag_ff;
         y_ff <= den_ff;
      end
      if (cmd.div_start) begin
         dvd_ff <= x_ff;
         dvs_ff <= y_ff;
         rem_ff <= '0;
      end
      if (cmd.quot_num) begin
         dvd_ff <= mag_ff;
         dvs_ff <= x_ff;
         rem_ff <= '0;
      end
      if (cmd.save_num) begin
         dvd_ff <= den_ff;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[W-2:0], 1'b0};
         if (!trial[W]) begin
            rem_ff <= trial[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
      end
      if (cmd.gcd_next) begin
         x_ff <= y_ff;
         y_ff <= rem_ff;
      end
      if (cmd.save_num) begin
         rnum_ff <= neg_ff ? -quo_ff : quo_ff;
      end
      if (cmd.finish) begin
         out_status <= status_ff;
         out_less   <= 1'b0;
         out_equal  <= 1'b0;
         out_num    <= '0;
         out_den    <= 63'd1;
         if (!special_ff) begin
            if (cmd.save_den) begin
               out_num <= rnum_ff;
               out_den <= quo_ff[62:0];
            end
         end else if ((status_ff == rau_pkg::STATUS_OK) &&
                      (mode_ff == rau_pkg::MODE_CMP)) begin
            out_less  <= p0_ff < p1_ff;
            out_equal <= p0_ff == p1_ff;
         end
      end
   end

   assign stat.special  = special_ff;
   assign stat.num_zero = (mag_ff == '0);
   assign stat.y_zero   = (y_ff == '0);
   assign stat.div_last = (cnt_ff == CntW'(W - 1));

endmodule

>>> hw/rtl/rau_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences operand capture, Euclid iterations, reduction and the result beat.
// ----------------------------------------------------------------------------
module rau_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  rau_pkg::stat_type  stat,
   output rau_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MULT, ST_COMB, ST_BRANCH, ST_GCD_TEST, ST_GCD_DIV,
      ST_GCD_NEXT, ST_NUM_DIV, ST_SAVE_NUM, ST_DEN_DIV, ST_FINISH, ST_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = accept;
      unique case (state_ff)
         ST_MULT:     cmd.mult = 1'b1;
         ST_COMB:     cmd.combine = 1'b1;
         ST_BRANCH:   cmd.gcd_init = 1'b1;
         ST_GCD_TEST: begin
            if (stat.y_zero) cmd.quot_num = 1'b1;
            else cmd.div_start = 1'b1;
         end
         ST_GCD_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_GCD_NEXT: begin
            cmd.gcd_next = 1'b1;
         end
         ST_NUM_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_SAVE_NUM: begin
            cmd.save_num = 1'b1;
         end
         ST_DEN_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish   = 1'b1;
            cmd.save_den = !stat.num_zero;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept) state_ff <= ST_MULT;
            ST_MULT: state_ff <= ST_COMB;
            ST_COMB: state_ff <= ST_BRANCH;
            ST_BRANCH: begin
               if (stat.special || stat.num_zero) state_ff <= ST_FINISH;
               else state_ff <= ST_GCD_TEST;
            end
            ST_GCD_TEST: state_ff <= stat.y_zero ? ST_NUM_DIV : ST_GCD_DIV;
            ST_GCD_DIV:  if (stat.div_last) state_ff <= ST_GCD_NEXT;
            ST_GCD_NEXT: state_ff <= ST_GCD_TEST;
            ST_NUM_DIV:  if (stat.div_last) state_ff <= ST_SAVE_NUM;
            ST_SAVE_NUM: state_ff <= ST_DEN_DIV;
            ST_DEN_DIV:  if (stat.div_last) state_ff <= ST_FINISH;
            ST_FINISH: begin
               state_ff     <= ST_OUT;
               rsp_valid_ff <= 1'b1;
            end
            ST_OUT: if (!rsp_valid_ff || rsp_tready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hw/rtl/rational_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides or compares two fractions and returns
// the result reduced to lowest terms.
// ----------------------------------------------------------------------------
// The request channel carries one operation per beat: a mode and two
// fractions. The response channel returns one beat per request with the
// reduced numerator and denominator, the compare flags and a status code.
// The block works on one request at a time. After a request beat it forms
// the cross products, then runs Euclid's algorithm with a shared 64-step
// restoring divider, one quotient bit per cycle, and divides numerator and
// denominator by the divisor found. Each Euclid iteration runs one division
// and moves the remainder into the Euclid pair. Errors, compares, unused
// modes and zero numerators skip the Euclid loop and the division. The
// divider sets the rate. The next request is taken only after the response
// beat is accepted.
// Reset empties the block and drops a pending response. While the receiver
// stalls, the response is held and no new request is taken.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[2:0], a_num[34:3], a_den[65:35], b_num[97:66], b_den[128:98], zero fill
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_num[63:0], res_den[126:64], less[127], equal[128], status[130:129]
   output logic [135:0] rsp_tdata
);

   localparam int AN = 3;
   localparam int AD = AN + 32;
   localparam int BN = AD + 31;
   localparam int BD = BN + 32;

   rau_pkg::cmd_type  cmd;
   rau_pkg::stat_type stat;
   logic [63:0] res_num;
   logic [62:0] res_den;
   logic        less, equal;
   logic [1:0]  status;

   rau_control u_control (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .cmd(cmd)
   );

   rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_mode(req_tdata[2:0]),
      .in_a_num(req_tdata[AN +: OPERAND_WIDTH]),
      .in_a_den(req_tdata[AD +: OPERAND_WIDTH-1]),
      .in_b_num(req_tdata[BN +: OPERAND_WIDTH]),
      .in_b_den(req_tdata[BD +: OPERAND_WIDTH-1]),
      .out_num(res_num), .out_den(res_den),
      .out_less(less), .out_equal(equal), .out_status(status)
   );

   assign rsp_tdata = {5'd0, status, equal, less, res_den, res_num};

endmodule

>>> tb/rational_arith_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives mode and fraction pairs into the request channel and checks every
// response beat against a predictor that computes the reduced fraction,
// the compare flags and the status code. Directed rows cover the field
// extremes, every mode and the error cases; random beats follow, with
// random idling on both sides, one long receiver stall and one drain pause.
// ----------------------------------------------------------------------------
module rational_arith_unit_tb;
   import rau_pkg::*;

   localparam int RandomBeats = 1250;
   localparam int StallLimit  = 50000;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
   } request_type;

   typedef struct packed {
      logic               chk;
      logic signed [63:0] res_num;
      logic [62:0]        res_den;
      logic               less;
      logic               equal;
      logic [1:0]         status;
   } answer_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;

   answer_type   pending_answers[$];
   int           failures = 0;
   int           idle_cycles = 0;
   int           beats_sent = 0;
   int           beats_checked = 0;
   bit           quiet_phase = 1'b0;
   bit           hold_off = 1'b0;
   bit           hold_done = 1'b0;

   rational_arith_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic answer_type reduce_fraction(request_type rq);
      answer_type         ans;
      logic signed [63:0] an, ad, bn, bd, num, den, lhs, rhs;
      logic [63:0]        mag, g;
      ans = '{chk: 1'b1, res_num: 0, res_den: 1, less: 0, equal: 0, status: STATUS_OK};
      an = rq.a_num;
      bn = rq.b_num;
      ad = {33'd0, rq.a_den};
      bd = {33'd0, rq.b_den};
      if (rq.mode <= MODE_CMP && (ad == 0 || bd == 0)) begin
         ans.status = STATUS_ZERO_DEN;
      end else if (rq.mode == MODE_DIV && bn == 0) begin
         ans.status = STATUS_DIV_ZERO;
      end else if (rq.mode == MODE_CMP) begin
         lhs = an * bd;
         rhs = ad * bn;
         ans.less = lhs < rhs;
         ans.equal = lhs == rhs;
      end else if (rq.mode <= MODE_DIV) begin
         case (rq.mode)
            MODE_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
            MODE_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
            MODE_MUL: begin num = an * bn; den = ad * bd; end
            default: begin num = an * bd; den = ad * bn; end
         endcase
         if (den < 0) begin
            num = -num;
            den = -den;
         end
         if (num != 0) begin
            mag = (num < 0) ? -num : num;
            g = euclid_gcd(mag, den);
            ans.res_num = (num < 0) ? -(mag / g) : (mag / g);
            ans.res_den = 63'(den / g);
         end
      end
      return ans;
   endfunction

   task automatic send_request(request_type rq);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {7'd0, rq.b_den, rq.b_num, rq.a_den, rq.a_num, rq.mode};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_answers.push_back(reduce_fraction(rq));
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic request_type random_request();
      request_type rq;
      rq.mode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 3))
         0: begin
            rq.a_num = $urandom; rq.b_num = $urandom;
            rq.a_den = 31'($urandom); rq.b_den = 31'($urandom);
         end
         1: begin
            rq.a_num = $signed(32'($urandom_range(0, 40))) - 20;
            rq.b_num = $signed(32'($urandom_range(0, 40))) - 20;
            rq.a_den = 31'($urandom_range(0, 30));
            rq.b_den = 31'($urandom_range(0, 30));
         end
         2: begin
            rq.a_num = $signed(32'($urandom_range(0, 2000))) * 36 - 36000;
            rq.a_den = 31'($urandom_range(1, 5000) * 12);
            rq.b_num = $signed(32'($urandom_range(0, 2000))) * 60 - 60000;
            rq.b_den = 31'($urandom_range(1, 5000) * 24);
         end
         default: begin
            rq.a_num = $urandom; rq.b_num = rq.a_num * 3;
            rq.a_den = 31'($urandom_range(1, 1000)); rq.b_den = 31'(rq.a_den * 3);
         end
      endcase
      return rq;
   endfunction

   // Directed rows; a set chk bit means the expected beat is typed in.
   request_type directed_req[] = '{
      '{MODE_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3},
      '{MODE_ADD, 32'sd5, 31'd0, 32'sd1, 31'd3},
      '{MODE_CMP, 32'sd5, 31'd7, 32'sd1, 31'd0},
      '{MODE_DIV, 32'sd5, 31'd7, 32'sd0, 31'd3},
      '{MODE_DIV, 32'sd5, 31'd0, 32'sd0, 31'd3},
      '{3'd5, 32'sd5, 31'd0, 32'sd1, 31'd3},
      '{3'd7, -32'sd1, 31'h7fffffff, -32'sd1, 31'h7fffffff},
      '{MODE_SUB, 32'sd3, 31'd4, 32'sd6, 31'd8},
      '{MODE_MUL, 32'sd0, 31'd9, -32'sd7, 31'd5},
      '{MODE_CMP, 32'sd1, 31'd2, 32'sd2, 31'd4},
      '{MODE_CMP, -32'sd1, 31'd2, 32'sd1, 31'd2},
      '{MODE_ADD, 32'h7fffffff, 31'h7fffffff, 32'h7fffffff, 31'h7fffffff},
      '{MODE_SUB, 32'h80000000, 31'd1, 32'h7fffffff, 31'd1},
      '{MODE_MUL, 32'h80000000, 31'd1, 32'h80000000, 31'd1},
      '{MODE_DIV, 32'h80000000, 31'h7fffffff, -32'sd1, 31'h7fffffff},
      '{MODE_DIV, 32'sd6, 31'd5, -32'sd4, 31'd15},
      '{MODE_ADD, -32'sd1, 31'd1, 32'sd1, 31'd1},
      '{MODE_CMP, 32'h80000000, 31'h7fffffff, 32'h7fffffff, 31'd1}
   };
   answer_type directed_ans[] = '{
      '{1, 64'sd5, 63'd6, 0, 0, STATUS_OK},
      '{1, 64'sd0, 63'd1, 0, 0, STATUS_ZERO_DEN},
      '{1, 64'sd0, 63'd1, 0, 0, STATUS_ZERO_DEN},
      '{1, 64'sd0, 63'd1, 0, 0, STATUS_DIV_ZERO},
      '{1, 64'sd0, 63'd1, 0, 0, STATUS_ZERO_DEN},
      '{1, 64'sd0, 63'd1, 0, 0, STATUS_OK},
      '{1, 64'sd0, 63'd1, 0, 0, STATUS_OK},
      '{1, 64'sd0, 63'd1, 0, 0, STATUS_OK},
      '{1, 64'sd0, 63'd1, 0, 0, STATUS_OK},
      '{1, 64'sd0, 63'd1, 0, 1, STATUS_OK},
      '{1, 64'sd0, 63'd1, 1, 0, STATUS_OK},
      '{1, 64'sd2, 63'd1, 0, 0, STATUS_OK},
      '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0},
      '{1, 64'sd0, 63'd1, 0, 0, STATUS_OK},
      '{1, 64'sd0, 63'd1, 1, 0, STATUS_OK}
   };

   initial begin
      answer_type typed;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < directed_req.size(); i++) begin
         send_request(directed_req[i]);
         typed = directed_ans[i];
         if (typed.chk && typed != pending_answers[$]) begin
            $error("predictor disagrees with typed row %0d", i);
            failures++;
         end
      end
      for (int i = 0; i < RandomBeats; i++) begin
         if (i == RandomBeats / 4) begin
            req_tvalid <= 1'b0;
            while (pending_answers.size() != 0) @(negedge clock);
         end
         if (i == RandomBeats / 2) hold_off = 1'b1;
         if (i == RandomBeats * 7 / 8) quiet_phase = 1'b1;
         send_request(random_request());
      end
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Sent %0d request beats over all modes, checked %0d responses.",
               beats_sent, beats_checked);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // The receiver pulls ready low on the falling edge.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_off && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(negedge clock);
            hold_done = 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (pending_answers.size() == 0) begin
            $error("response beat with no request outstanding");
            failures++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[63:0] !== want.res_num) begin
               $error("res_num expected %0d actual %0d", want.res_num,
                      $signed(rsp_tdata[63:0]));
               failures++;
            end
            if (rsp_tdata[126:64] !== want.res_den) begin
               $error("res_den expected %0d actual %0d", want.res_den,
                      rsp_tdata[126:64]);
               failures++;
            end
            if (rsp_tdata[127] !== want.less) begin
               $error("less expected %0d actual %0d", want.less, rsp_tdata[127]);
               failures++;
            end
            if (rsp_tdata[128] !== want.equal) begin
               $error("equal expected %0d actual %0d", want.equal, rsp_tdata[128]);
               failures++;
            end
            if (rsp_tdata[130:129] !== want.status) begin
               $error("status expected %0d actual %0d", want.status,
                      rsp_tdata[130:129]);
               failures++;
            end
         end
      end
   end

   // A single request may run a long Euclid loop, and the long
   // receiver stall adds more; the limit covers both many times over.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

>>> files.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_datapath.sv
hw/rtl/rau_control.sv
hw/rtl/rational_arith_unit.sv
tb/rational_arith_unit_tb.sv
